// ===== rtl/core/linear_regression_gradient_descent_macros.svh =====
// Assertion helpers shared by the RTL.
// Every macro assumes the module has aclk and aresetn in scope.
`ifndef LINEAR_REGRESSION_GRADIENT_DESCENT_MACROS_SVH
`define LINEAR_REGRESSION_GRADIENT_DESCENT_MACROS_SVH

// Checks cons in the same cycle as ante.
`define LRGD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks cons in the cycle after ante.
`define LRGD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lrgd_pkg.sv =====
`default_nettype none
package lrgd_pkg;

    localparam int MAX_SAMPLES  = 512;
    localparam int MAX_FEATURES = 8;
    localparam int AW  = $clog2(MAX_SAMPLES);  // sample address
    localparam int CW  = AW + 1;               // sample count
    localparam int DVW = CW + 1;               // divisor, up to 2 * count
    localparam int FW  = 16;                   // Q4.12 sample value
    localparam int KW  = 32;                   // Q16.16 coefficient / error
    localparam int PW  = KW + FW;              // lane product
    localparam int SW  = PW + 4;               // prediction sum
    localparam int GW  = 58;                   // gradient / cost accumulator
    localparam int DCW = $clog2(GW + 1);       // divider step counter
    localparam int LRW = 16;                   // learning rate
    localparam int MW  = GW + LRW;             // step magnitude
    localparam int RW  = MW + 1 - 28;          // rounded step
    localparam int NW  = 4;                    // feature count / index
    localparam int IW  = 2;                    // register index

    localparam logic [IW-1:0] REG_LEARNING_RATE   = 2'd0;
    localparam logic [IW-1:0] REG_ITERATION_COUNT = 2'd1;
    localparam logic [IW-1:0] REG_FEATURES_IN_USE = 2'd2;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [AW-1:0] rd_addr;
        logic          grad_mode;
        logic          acc_clr;
        logic          acc_en;
    } lane_ctrl_t;

    function automatic logic signed [KW-1:0] sat_s32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return -32'sh8000_0000;
        end
        return v[KW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lrgd_lane.sv =====
`default_nettype none
module lrgd_lane (
    input  wire logic                          aclk,
    input  wire lrgd_pkg::lane_ctrl_t          ctrl,
    input  wire logic signed [lrgd_pkg::FW-1:0] wr_data,
    input  wire logic signed [lrgd_pkg::KW-1:0] coef,
    input  wire logic signed [lrgd_pkg::KW-1:0] err,
    output logic signed [lrgd_pkg::PW-1:0]      prod,
    output logic signed [lrgd_pkg::GW-1:0]      acc
);
    import lrgd_pkg::*;

    logic signed [FW-1:0] mem [MAX_SAMPLES];
    logic signed [FW-1:0] rd_reg;
    logic signed [KW-1:0] op_a;
    logic signed [PW-1:0] prod_reg;
    logic signed [GW-1:0] acc_reg;

    // error times feature in the gradient pass, coefficient times feature otherwise
    assign op_a = ctrl.grad_mode ? err : coef;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        rd_reg   <= mem[ctrl.rd_addr];
        prod_reg <= PW'(op_a) * PW'(rd_reg);
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + GW'(prod_reg);
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/core/lrgd_div.sv =====
`default_nettype none
module lrgd_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [lrgd_pkg::GW-1:0]  dividend,
    input  wire logic [lrgd_pkg::DVW-1:0] divisor,
    output logic                          done,
    output logic [lrgd_pkg::GW-1:0]       quotient
);
    import lrgd_pkg::*;

    logic           busy_reg;
    logic           done_reg;
    logic [DCW-1:0] cnt_reg;
    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] dsr_reg;
    logic [GW-1:0]  quo_reg;
    logic [DVW:0]   trial;
    logic           fits;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[GW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                quo_reg  <= dividend;
            end else if (busy_reg) begin
                rem_reg <= fits ? DVW'(trial - {1'b0, dsr_reg}) : DVW'(trial);
                quo_reg <= {quo_reg[GW-2:0], fits};
                cnt_reg <= cnt_reg + DCW'(1);
                if (cnt_reg == DCW'(GW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/linear_regression_gradient_descent.sv =====
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: feature_0..7, target_value; tlast: last_sample
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: coefficient_index, value, final_cost; tlast
// cfg      in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Sample beats are taken while loading; the store holds 512 samples.
// Each training iteration runs an error pass, a gradient pass and a per-coefficient update;
// a final error pass and a cost division close the run, and one serial divider is shared
// by the coefficient updates and the cost division.
// Input stalls (tready low) for the whole run until the last result beat is taken.
// Reset (aresetn low, synchronous) restores the registers and empties the sample set.
`default_nettype none
`include "linear_regression_gradient_descent_macros.svh"
module linear_regression_gradient_descent (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // feature_0 [15:0] .. feature_7 [127:112], target_value [143:128]
    input  wire logic [143:0]            s_axis_tdata,
    input  wire logic                    s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // coefficient_index [3:0], coefficient_value [35:4], final_cost [67:36], zero [71:68]
    output logic [71:0]                  m_axis_tdata,
    output logic                         m_axis_tlast,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [lrgd_pkg::IW-1:0] cfg_index,
    input  wire logic [15:0]             cfg_data
);
    import lrgd_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_ERR, S_GRAD, S_DIVSTART, S_DIVWAIT,
        S_MUL, S_RND, S_WR, S_NEXTIT, S_COSTWAIT, S_OUT
    } state_t;

    state_t state_reg;

    logic [LRW-1:0] lr_reg;
    logic [15:0]    iter_reg;
    logic [NW-1:0]  fiu_reg;
    logic [CW-1:0]  count_reg;
    logic [NW-1:0]  nparams_reg;
    logic [15:0]    it_reg;
    logic           final_reg;
    logic [CW-1:0]  idx_reg;
    logic [5:0]     v_reg;
    logic [AW-1:0]  tag_reg [4];

    logic signed [KW-1:0] coef_reg [MAX_FEATURES + 1];
    logic signed [KW-1:0] next_reg [MAX_FEATURES + 1];

    logic signed [FW-1:0] tgt_mem [MAX_SAMPLES];
    logic signed [KW-1:0] err_mem [MAX_SAMPLES];
    logic signed [FW-1:0] tgt_rd_reg;
    logic signed [KW-1:0] err_rd_reg;

    logic signed [SW-1:0] tneg_reg;
    logic signed [SW-1:0] s0_reg, s1_reg, s2_reg, sum_reg;
    logic signed [KW-1:0] e_reg;
    logic [63:0]          sq_reg;
    logic [GW-1:0]        cost_acc_reg;
    logic [KW-1:0]        cost_reg;
    logic signed [GW-1:0] bprod_reg;
    logic signed [GW-1:0] bacc_reg;

    logic [NW-1:0]  j_reg;
    logic           neg_reg;
    logic [MW-1:0]  mq_reg;
    logic [MW-1:0]  p_reg;
    logic [LRW-1:0] lr_sh_reg;
    logic [NW-1:0]  mcnt_reg;
    logic signed [RW-1:0] rnd_reg;

    logic           div_start_reg;
    logic [GW-1:0]  div_dividend_reg;
    logic [DVW-1:0] div_divisor_reg;
    logic           div_done;
    logic [GW-1:0]  div_q;

    logic           m_valid_reg;
    logic [NW-1:0]  out_idx_reg;
    logic [KW-1:0]  out_val_reg;
    logic [KW-1:0]  out_cost_reg;
    logic           out_last_reg;

    lane_ctrl_t           lane_ctrl;
    logic signed [PW-1:0] lane_prod [MAX_FEATURES];
    logic signed [GW-1:0] lane_acc  [MAX_FEATURES];

    logic                 s_beat, m_beat, store_beat, issue, pass_done;
    logic                 err_we;
    logic signed [SW-1:0] rsum;
    logic signed [KW-1:0] err_new;
    logic signed [GW-1:0] g_sel;
    logic [GW-1:0]        g_mag;
    logic signed [MW:0]   stp;
    logic signed [MW:0]   stp_r;
    logic [NW-1:0]        nf_clamped;
    logic [NW-1:0]        j_nxt;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign cfg_ready     = 1'b1;
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign m_beat        = m_axis_tvalid && m_axis_tready;
    assign store_beat    = s_beat && (count_reg < CW'(MAX_SAMPLES));
    assign issue         = ((state_reg == S_ERR) || (state_reg == S_GRAD)) && (idx_reg < count_reg);
    assign pass_done     = (idx_reg == count_reg) && (v_reg == '0);

    // features_in_use 0 counts as one, anything above the lane count as all lanes
    always_comb begin
        if (fiu_reg == '0) begin
            nf_clamped = NW'(1);
        end else if (fiu_reg > NW'(MAX_FEATURES)) begin
            nf_clamped = NW'(MAX_FEATURES);
        end else begin
            nf_clamped = fiu_reg;
        end
    end

    always_comb begin
        lane_ctrl.wr_en     = store_beat;
        lane_ctrl.wr_addr   = count_reg[AW-1:0];
        lane_ctrl.rd_addr   = idx_reg[AW-1:0];
        lane_ctrl.grad_mode = (state_reg == S_GRAD);
        lane_ctrl.acc_clr   = (state_reg == S_ERR) && pass_done && !final_reg;
        lane_ctrl.acc_en    = (state_reg == S_GRAD) && v_reg[1];
    end

    for (genvar g = 0; g < MAX_FEATURES; g++) begin : g_lane
        lrgd_lane u_lane (
            .aclk    (aclk),
            .ctrl    (lane_ctrl),
            .wr_data (s_axis_tdata[g*FW +: FW]),
            .coef    (coef_reg[g+1]),
            .err     (err_rd_reg),
            .prod    (lane_prod[g]),
            .acc     (lane_acc[g])
        );
    end

    lrgd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  (div_divisor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // error: round half up from Q.28 to Q16.16, then saturate
    assign rsum    = (sum_reg + SW'(2048)) >>> 12;
    assign err_new = sat_s32(64'(rsum));
    assign err_we  = (state_reg == S_ERR) && v_reg[3];

    // gradient of the coefficient in work, as sign and magnitude for the divider
    assign g_sel = (j_reg == '0) ? bacc_reg : lane_acc[3'(j_reg - NW'(1))];
    assign g_mag = g_sel[GW-1] ? GW'(-g_sel) : GW'(g_sel);

    assign stp   = neg_reg ? -$signed({1'b0, p_reg}) : $signed({1'b0, p_reg});
    assign stp_r = (stp + (MW+1)'(1 << 27)) >>> 28;
    assign j_nxt = j_reg + NW'(1);

    // sample stores and error store: written on a stored beat or an error write, read every cycle
    always_ff @(posedge aclk) begin
        if (store_beat) begin
            tgt_mem[count_reg[AW-1:0]] <= s_axis_tdata[MAX_FEATURES*FW +: FW];
        end
        if (err_we) begin
            err_mem[tag_reg[3]] <= err_new;
        end
        tgt_rd_reg <= tgt_mem[idx_reg[AW-1:0]];
        err_rd_reg <= err_mem[idx_reg[AW-1:0]];
    end

    // datapath stages of the error and gradient passes
    always_ff @(posedge aclk) begin
        tneg_reg  <= -(SW'(tgt_rd_reg) <<< 16);
        s0_reg    <= SW'(lane_prod[0]) + SW'(lane_prod[1]) + SW'(lane_prod[2]);
        s1_reg    <= SW'(lane_prod[3]) + SW'(lane_prod[4]) + SW'(lane_prod[5]);
        s2_reg    <= SW'(lane_prod[6]) + SW'(lane_prod[7]) + (SW'(coef_reg[0]) <<< 12)
                     + tneg_reg;
        sum_reg   <= s0_reg + s1_reg + s2_reg;
        e_reg     <= err_new;
        sq_reg    <= 64'(e_reg) * 64'(e_reg);
        bprod_reg <= GW'(err_rd_reg) <<< 12;
        tag_reg[0] <= idx_reg[AW-1:0];
        for (int k = 1; k < 4; k++) begin
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            lr_reg        <= LRW'(655);
            iter_reg      <= 16'd1000;
            fiu_reg       <= NW'(3);
            count_reg     <= '0;
            v_reg         <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            final_reg     <= 1'b0;
            idx_reg       <= '0;
        end else begin
            div_start_reg <= 1'b0;
            v_reg         <= {v_reg[4:0], issue};
            if (issue) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LEARNING_RATE:   lr_reg   <= cfg_data;
                    REG_ITERATION_COUNT: iter_reg <= cfg_data;
                    REG_FEATURES_IN_USE: fiu_reg  <= cfg_data[NW-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_LOAD: begin
                    if (store_beat) begin
                        count_reg <= count_reg + CW'(1);
                    end
                    // last beat: clear the model and start the run
                    if (s_beat && s_axis_tlast) begin
                        for (int k = 0; k <= MAX_FEATURES; k++) begin
                            coef_reg[k] <= '0;
                            next_reg[k] <= '0;
                        end
                        it_reg      <= '0;
                        nparams_reg <= nf_clamped + NW'(1);
                        state_reg   <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    idx_reg      <= '0;
                    cost_acc_reg <= '0;
                    if (count_reg == '0) begin
                        cost_reg  <= '0;
                        state_reg <= S_OUT;
                        m_valid_reg  <= 1'b1;
                        out_idx_reg  <= '0;
                        out_val_reg  <= coef_reg[0];
                        out_cost_reg <= '0;
                        out_last_reg <= 1'b0;
                    end else begin
                        final_reg <= !(it_reg < iter_reg);
                        state_reg <= S_ERR;
                    end
                end
                S_ERR: begin
                    if (v_reg[5]) begin
                        cost_acc_reg <= cost_acc_reg + GW'((sq_reg + 64'd32768) >> 16);
                    end
                    if (pass_done) begin
                        if (final_reg) begin
                            div_start_reg    <= 1'b1;
                            div_dividend_reg <= cost_acc_reg;
                            div_divisor_reg  <= {count_reg, 1'b0};
                            state_reg        <= S_COSTWAIT;
                        end else begin
                            idx_reg   <= '0;
                            bacc_reg  <= '0;
                            state_reg <= S_GRAD;
                        end
                    end
                end
                S_GRAD: begin
                    if (v_reg[1]) begin
                        bacc_reg <= bacc_reg + bprod_reg;
                    end
                    if (pass_done) begin
                        j_reg     <= '0;
                        state_reg <= S_DIVSTART;
                    end
                end
                S_DIVSTART: begin
                    div_start_reg    <= 1'b1;
                    div_dividend_reg <= g_mag;
                    div_divisor_reg  <= DVW'(count_reg);
                    neg_reg          <= g_sel[GW-1];
                    state_reg        <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (div_done) begin
                        mq_reg    <= MW'(div_q);
                        p_reg     <= '0;
                        lr_sh_reg <= lr_reg;
                        mcnt_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    // shift-add, one learning rate bit a cycle
                    if (lr_sh_reg[0]) begin
                        p_reg <= p_reg + mq_reg;
                    end
                    mq_reg    <= mq_reg << 1;
                    lr_sh_reg <= lr_sh_reg >> 1;
                    mcnt_reg  <= mcnt_reg + NW'(1);
                    if (mcnt_reg == NW'(LRW - 1)) begin
                        state_reg <= S_RND;
                    end
                end
                S_RND: begin
                    rnd_reg   <= stp_r[RW-1:0];
                    state_reg <= S_WR;
                end
                S_WR: begin
                    next_reg[j_reg] <= sat_s32(64'(coef_reg[j_reg]) - 64'(rnd_reg));
                    if (j_nxt == nparams_reg) begin
                        state_reg <= S_NEXTIT;
                    end else begin
                        j_reg     <= j_nxt;
                        state_reg <= S_DIVSTART;
                    end
                end
                S_NEXTIT: begin
                    for (int k = 0; k <= MAX_FEATURES; k++) begin
                        coef_reg[k] <= next_reg[k];
                    end
                    it_reg    <= it_reg + 16'd1;
                    state_reg <= S_CHECK;
                end
                S_COSTWAIT: begin
                    if (div_done) begin
                        cost_reg     <= (div_q > GW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                  : div_q[KW-1:0];
                        state_reg    <= S_OUT;
                        m_valid_reg  <= 1'b1;
                        out_idx_reg  <= '0;
                        out_val_reg  <= coef_reg[0];
                        out_cost_reg <= '0;
                        out_last_reg <= 1'b0;
                    end
                end
                S_OUT: begin
                    // advance one coefficient per beat; the last one carries the cost
                    if (m_beat) begin
                        if (out_last_reg) begin
                            m_valid_reg <= 1'b0;
                            count_reg   <= '0;
                            state_reg   <= S_LOAD;
                        end else begin
                            out_idx_reg  <= out_idx_reg + NW'(1);
                            out_val_reg  <= coef_reg[out_idx_reg + NW'(1)];
                            out_last_reg <= (out_idx_reg + NW'(2) == nparams_reg);
                            out_cost_reg <= (out_idx_reg + NW'(2) == nparams_reg) ? cost_reg
                                                                                  : '0;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, out_cost_reg, out_val_reg, out_idx_reg};
    assign m_axis_tlast  = out_last_reg;

    `LRGD_ASSERT_IMP(a_no_result_in_load, s_axis_tready, !m_axis_tvalid, "result while loading")
    `LRGD_ASSERT_IMP(a_last_index, m_axis_tvalid && m_axis_tlast, out_idx_reg == nparams_reg - NW'(1), "last result index wrong")
    `LRGD_ASSERT_NXT(a_count_cleared, m_beat && m_axis_tlast, count_reg == '0, "sample count kept after run")
    `LRGD_ASSERT_IMP(a_err_write_pass, err_we, idx_reg <= count_reg && count_reg != '0, "error written outside a pass")

endmodule
`default_nettype wire
